// ===== rtl/clel_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package clel_pkg;

  localparam int unsigned IDX_W  = 8;
  localparam int unsigned DEPTH  = 2 ** IDX_W;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned ST_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    F_READ   = 3'd0,
    F_WRITE  = 3'd1,
    F_APPEND = 3'd2,
    F_DROP   = 3'd3,
    F_INSERT = 3'd4,
    F_REMOVE = 3'd5
  } func_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_READ_WAIT,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_FIN
  } state_t;

  localparam logic [0:0] REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic latch;
    logic decide;
    logic shift_init;
    logic shift_rd;
    logic wr_pos;
    logic wr_cnt;
    logic cnt_inc;
    logic cnt_dec;
    logic cap_rd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic        err;
    logic [FUNC_W-1:0] func;
    logic        last_mv;
    logic        rm_none;
    logic        out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/clel_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clel_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/clel_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clel_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire clel_pkg::sts_t sts,
  output clel_pkg::cmd_t     cmd
);

  clel_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clel_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      clel_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = clel_pkg::S_DECIDE;
        end
      end
      clel_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = clel_pkg::S_FIN;
        if (!sts.err) begin
          case (sts.func)
            clel_pkg::F_READ: begin
              state_nxt = clel_pkg::S_READ_WAIT;
            end
            clel_pkg::F_WRITE: begin
              cmd.wr_pos = 1'b1;
            end
            clel_pkg::F_APPEND: begin
              cmd.wr_cnt  = 1'b1;
              cmd.cnt_inc = 1'b1;
            end
            clel_pkg::F_DROP: begin
              cmd.cnt_dec = 1'b1;
            end
            clel_pkg::F_INSERT: begin
              cmd.shift_init = 1'b1;
              state_nxt      = clel_pkg::S_SHIFT;
            end
            clel_pkg::F_REMOVE: begin
              if (sts.rm_none) begin
                cmd.cnt_dec = 1'b1;
              end else begin
                cmd.shift_init = 1'b1;
                state_nxt      = clel_pkg::S_SHIFT;
              end
            end
            default: begin
              state_nxt = clel_pkg::S_FIN;
            end
          endcase
        end
      end
      clel_pkg::S_READ_WAIT: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = clel_pkg::S_FIN;
      end
      clel_pkg::S_SHIFT: begin
        cmd.shift_rd = 1'b1;
        if (sts.last_mv) begin
          state_nxt = clel_pkg::S_DRAIN;
        end
      end
      clel_pkg::S_DRAIN: begin
        if (sts.func == clel_pkg::F_INSERT) begin
          state_nxt = clel_pkg::S_PUT;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = clel_pkg::S_FIN;
        end
      end
      clel_pkg::S_PUT: begin
        cmd.wr_pos  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = clel_pkg::S_FIN;
      end
      clel_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = clel_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = clel_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/clel_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clel_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire clel_pkg::cmd_t                      cmd,
  output clel_pkg::sts_t                           sts,
  input  wire logic [clel_pkg::CNT_W-1:0]          capacity,
  input  wire logic [clel_pkg::FUNC_W-1:0]         in_func,
  input  wire logic [clel_pkg::IDX_W-1:0]          in_position,
  input  wire logic signed [clel_pkg::WORD_W-1:0]  in_word_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [clel_pkg::WORD_W-1:0]       out_word_out,
  output logic [clel_pkg::ST_W-1:0]                out_status,
  output logic [clel_pkg::CNT_W-1:0]               out_fill
);

  logic [clel_pkg::FUNC_W-1:0]  func_r;
  logic [clel_pkg::IDX_W-1:0]   pos_r;
  logic [clel_pkg::WORD_W-1:0]  word_r;
  logic [clel_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [clel_pkg::IDX_W-1:0]   ptr_r, ptr_nxt;
  logic                         wb_vld_r;
  logic [clel_pkg::IDX_W-1:0]   wb_addr_r, wb_addr_nxt;
  logic [clel_pkg::WORD_W-1:0]  res_r;
  clel_pkg::status_t            st_r, st_calc;
  logic                         out_valid_r;
  logic [clel_pkg::WORD_W-1:0]  out_word_r;
  logic [clel_pkg::ST_W-1:0]    out_status_r;
  logic [clel_pkg::CNT_W-1:0]   out_fill_r;

  logic [clel_pkg::CNT_W-1:0]   limit;
  logic                         idx_ok, full, is_ins;
  logic                         ram_we;
  logic [clel_pkg::IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [clel_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;

  assign limit  = (capacity > clel_pkg::CNT_W'(clel_pkg::DEPTH))
                  ? clel_pkg::CNT_W'(clel_pkg::DEPTH) : capacity;
  assign idx_ok = {1'b0, pos_r} < cnt_r;
  assign full   = cnt_r >= limit;
  assign is_ins = func_r == clel_pkg::F_INSERT;

  always_comb begin
    st_calc = clel_pkg::ST_OK;
    case (func_r)
      clel_pkg::F_READ, clel_pkg::F_WRITE, clel_pkg::F_REMOVE: begin
        if (!idx_ok) st_calc = clel_pkg::ST_BAD_INDEX;
      end
      clel_pkg::F_APPEND: begin
        if (full) st_calc = clel_pkg::ST_FULL;
      end
      clel_pkg::F_DROP: begin
        if (cnt_r == '0) st_calc = clel_pkg::ST_EMPTY;
      end
      clel_pkg::F_INSERT: begin
        if (full) begin
          st_calc = clel_pkg::ST_FULL;
        end else if (!idx_ok) begin
          st_calc = clel_pkg::ST_BAD_INDEX;
        end
      end
      default: begin
        st_calc = clel_pkg::ST_OK;
      end
    endcase
  end

  assign sts.err      = st_calc != clel_pkg::ST_OK;
  assign sts.func     = func_r;
  assign sts.last_mv  = is_ins ? (ptr_r == pos_r) : ({1'b0, ptr_r} + 1'b1 == cnt_r);
  assign sts.rm_none  = {1'b0, pos_r} + 1'b1 == cnt_r;
  assign sts.out_free = !out_valid_r || out_ready;

  // shift pipeline: read at ptr, write the returned word one slot over next cycle
  assign ram_raddr = cmd.shift_rd ? ptr_r : pos_r;
  assign ram_we    = wb_vld_r || cmd.wr_pos || cmd.wr_cnt;
  assign ram_waddr = wb_vld_r ? wb_addr_r
                   : (cmd.wr_pos ? pos_r : cnt_r[clel_pkg::IDX_W-1:0]);
  assign ram_wdata = wb_vld_r ? ram_rdata : word_r;

  clel_ram #(
    .WIDTH (clel_pkg::WORD_W),
    .DEPTH (clel_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    ptr_nxt     = ptr_r;
    wb_addr_nxt = wb_addr_r;
    if (cmd.shift_init) begin
      ptr_nxt = is_ins ? clel_pkg::IDX_W'(cnt_r - 1'b1) : pos_r + 1'b1;
    end else if (cmd.shift_rd) begin
      ptr_nxt     = is_ins ? ptr_r - 1'b1 : ptr_r + 1'b1;
      wb_addr_nxt = is_ins ? ptr_r + 1'b1 : ptr_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      wb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      wb_vld_r <= cmd.shift_rd;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    wb_addr_r <= wb_addr_nxt;
    if (cmd.latch) begin
      func_r <= in_func;
      pos_r  <= in_position;
      word_r <= in_word_in;
    end
    if (cmd.decide) begin
      st_r  <= st_calc;
      res_r <= '0;
    end else if (cmd.cap_rd) begin
      res_r <= ram_rdata;
    end
    if (cmd.load_out) begin
      out_word_r   <= res_r;
      out_status_r <= st_r;
      out_fill_r   <= cnt_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word_out = out_word_r;
  assign out_status   = out_status_r;
  assign out_fill     = out_fill_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= clel_pkg::CNT_W'(clel_pkg::DEPTH))
    else $error("element count beyond depth");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(wb_vld_r && (cmd.wr_pos || cmd.wr_cnt)))
    else $error("write port contention");

  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transaction");

  a_err_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decide && st_calc != clel_pkg::ST_OK) |=> $stable(cnt_r))
    else $error("failed request changed count");

endmodule

`default_nettype wire

// ===== rtl/contiguous_list_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bounded list of up to 256 signed 32-bit words in a single-port-write,
// registered-read RAM. One request in flight at a time; a finished result is
// held in an output register so the next request can be taken the cycle after.
// Write, append, drop and any failing request pass through the decide state
// to the finish state; read adds a RAM read-wait state. Insert and remove
// move one element per cycle through the RAM (read one slot, write its
// neighbour the next cycle), then drain; insert then writes the new word,
// remove drops its count. Remove goes straight to finish when it drops the
// last element. A result not yet taken holds the next one back.
// Capacity (register 0): append and insert report full once the count reaches
// min(capacity, 256); write it only while idle.

module contiguous_list_engine_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [clel_pkg::FUNC_W-1:0]         in_func,
  input  wire logic [clel_pkg::IDX_W-1:0]          in_position,
  input  wire logic signed [clel_pkg::WORD_W-1:0]  in_word_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [clel_pkg::WORD_W-1:0]       out_word_out,
  output logic [clel_pkg::ST_W-1:0]                out_status,
  output logic [clel_pkg::CNT_W-1:0]               out_fill,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  clel_pkg::cmd_t cmd;
  clel_pkg::sts_t sts;
  logic [clel_pkg::CNT_W-1:0] cap_r;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == clel_pkg::REG_CAPACITY;
  assign prdata  = reg_sel ? {{(32 - clel_pkg::CNT_W){1'b0}}, cap_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= clel_pkg::CNT_W'(clel_pkg::DEPTH);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      cap_r <= pwdata[clel_pkg::CNT_W-1:0];
    end
  end

  clel_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  clel_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .capacity     (cap_r),
    .in_func      (in_func),
    .in_position  (in_position),
    .in_word_in   (in_word_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word_out (out_word_out),
    .out_status   (out_status),
    .out_fill     (out_fill)
  );

endmodule

`default_nettype wire

// ===== bench/list_checker.sv =====
`timescale 1ns / 1ps

module list_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [clel_pkg::FUNC_W-1:0]         in_func,
  input  logic [clel_pkg::IDX_W-1:0]          in_position,
  input  logic signed [clel_pkg::WORD_W-1:0]  in_word_in,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [clel_pkg::WORD_W-1:0]  out_word_out,
  input  logic [clel_pkg::ST_W-1:0]           out_status,
  input  logic [clel_pkg::CNT_W-1:0]          out_fill,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  results_seen
);
  import clel_pkg::*;

  localparam logic [2:0] CAP_ADDR = 3'(4 * int'(REG_CAPACITY));

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    status_t                  status;
    logic [CNT_W-1:0]         fill;
  } list_reply_t;

  list_reply_t              expected_replies[$];
  logic signed [WORD_W-1:0] shadow_words [DEPTH];
  logic [CNT_W-1:0]         shadow_count;
  logic [CNT_W-1:0]         shadow_cap;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, exp_v, got_v);
    mismatches++;
  endtask

  function automatic list_reply_t apply_list_op(input logic [FUNC_W-1:0] op,
                                                input logic [IDX_W-1:0] pos,
                                                input logic signed [WORD_W-1:0] word);
    list_reply_t r;
    int unsigned lim;
    logic        idx_ok;
    logic        full;
    r.word   = '0;
    r.status = ST_OK;
    lim      = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
    idx_ok   = pos < shadow_count;
    full     = shadow_count >= lim;
    case (op)
      F_READ: begin
        if (idx_ok) r.word = shadow_words[pos];
        else r.status = ST_BAD_INDEX;
      end
      F_WRITE: begin
        if (idx_ok) shadow_words[pos] = word;
        else r.status = ST_BAD_INDEX;
      end
      F_APPEND: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_count[IDX_W-1:0]] = word;
          shadow_count++;
        end
      end
      F_DROP: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_count--;
      end
      F_INSERT: begin
        if (full) begin
          r.status = ST_FULL;
        end else if (!idx_ok) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (int i = shadow_count; i > pos; i--)
            shadow_words[IDX_W'(i)] = shadow_words[IDX_W'(i-1)];
          shadow_words[pos] = word;
          shadow_count++;
        end
      end
      F_REMOVE: begin
        if (!idx_ok) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++)
            shadow_words[IDX_W'(i)] = shadow_words[IDX_W'(i+1)];
          shadow_count--;
        end
      end
      default: ;
    endcase
    r.fill = shadow_count;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    list_reply_t exp_r;
    if (!rst_n) begin
      shadow_count = '0;
      shadow_cap   = CNT_W'(DEPTH);
      expected_replies.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
        shadow_cap = pwdata[CNT_W-1:0];
      if (in_valid && in_ready)
        expected_replies.push_back(apply_list_op(in_func, in_position, in_word_in));
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with no request outstanding", '0, out_word_out);
        end else begin
          exp_r = expected_replies.pop_front();
          if (out_word_out !== exp_r.word)
            report_mismatch("word_out", exp_r.word, out_word_out);
          if (out_status !== exp_r.status)
            report_mismatch("status", 32'(exp_r.status), 32'(out_status));
          if (out_fill !== exp_r.fill)
            report_mismatch("fill", 32'(exp_r.fill), 32'(out_fill));
        end
      end
    end
    outstanding = expected_replies.size();
  end

endmodule

// ===== bench/tb_contiguous_list_engine_top.sv =====
`timescale 1ns / 1ps

module tb_contiguous_list_engine_top;
  import clel_pkg::*;

  typedef enum int {MIX_GROW, MIX_DRAIN, MIX_EVEN} op_mix_t;

  localparam logic [2:0]        CAP_ADDR   = 3'(4 * int'(REG_CAPACITY));
  localparam logic [FUNC_W-1:0] F_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] F_SPARE_HI = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [FUNC_W-1:0]        in_func;
  logic [IDX_W-1:0]         in_position;
  logic signed [WORD_W-1:0] in_word_in;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [WORD_W-1:0] out_word_out;
  logic [ST_W-1:0]          out_status;
  logic [CNT_W-1:0]         out_fill;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [2:0]               paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  int mismatches;
  int outstanding;
  int results_seen;
  int items_sent = 0;
  int settings_used = 0;
  bit calm = 1'b0;

  always #10 clk = ~clk;

  contiguous_list_engine_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_position  (in_position),
    .in_word_in   (in_word_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word_out (out_word_out),
    .out_status   (out_status),
    .out_fill     (out_fill),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  list_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_position  (in_position),
    .in_word_in   (in_word_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word_out (out_word_out),
    .out_status   (out_status),
    .out_fill     (out_fill),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  task automatic send(input logic [FUNC_W-1:0] op, input logic [IDX_W-1:0] pos,
                      input logic [WORD_W-1:0] word);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= op;
    in_position <= pos;
    in_word_in  <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(input int unsigned cap);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= cap;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_op(input op_mix_t mix);
    int r;
    int w_app;
    int w_ins;
    int w_rd;
    int w_wr;
    int w_drop;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:  begin w_app = 35; w_ins = 20; w_rd = 15; w_wr = 12; w_drop = 8;  end
      MIX_DRAIN: begin w_app = 8;  w_ins = 8;  w_rd = 15; w_wr = 12; w_drop = 30; end
      default:   begin w_app = 20; w_ins = 15; w_rd = 20; w_wr = 15; w_drop = 14; end
    endcase
    if (r < 2) return (r == 0) ? F_SPARE_LO : F_SPARE_HI;
    r -= 2;
    if (r < w_app) return F_APPEND;
    r -= w_app;
    if (r < w_ins) return F_INSERT;
    r -= w_ins;
    if (r < w_rd) return F_READ;
    r -= w_rd;
    if (r < w_wr) return F_WRITE;
    r -= w_wr;
    if (r < w_drop) return F_DROP;
    return F_REMOVE;
  endfunction

  task automatic run_phase(input int n, input op_mix_t mix, input int unsigned pos_hi);
    logic [IDX_W-1:0] pos;
    repeat (n) begin
      if ($urandom_range(0, 3) != 0)
        pos = IDX_W'($urandom_range(0, (pos_hi > 255) ? 255 : pos_hi));
      else pos = IDX_W'($urandom_range(0, 255));
      send(pick_op(mix), pos, pick_word());
    end
  endtask

  initial begin : sink
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm) begin
        hold = 0;
        out_ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 14) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned cap_pick;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_func     <= '0;
    in_position <= '0;
    in_word_in  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, spare codes, then append, read, write, insert and remove
    send(F_DROP, 8'd0, 32'h0);
    send(F_READ, 8'd0, 32'h0);
    send(F_WRITE, 8'd0, 32'h1111_1111);
    send(F_REMOVE, 8'd0, 32'h0);
    send(F_INSERT, 8'd0, 32'h2222_2222);
    send(F_SPARE_LO, 8'd3, 32'h0);
    send(F_SPARE_HI, 8'd255, 32'hffff_ffff);
    send(F_APPEND, 8'd0, 32'h8000_0000);
    send(F_APPEND, 8'd255, 32'h7fff_ffff);
    send(F_APPEND, 8'd0, 32'h0);
    send(F_APPEND, 8'd0, 32'hffff_ffff);
    send(F_READ, 8'd0, 32'h0);
    send(F_READ, 8'd3, 32'h0);
    send(F_READ, 8'd255, 32'h0);
    send(F_WRITE, 8'd2, 32'h1234_5678);
    send(F_INSERT, 8'd0, 32'ha5a5_a5a5);
    send(F_INSERT, 8'd4, 32'h5a5a_5a5a);
    send(F_INSERT, 8'd6, 32'h0);
    send(F_REMOVE, 8'd0, 32'h0);
    send(F_REMOVE, 8'd4, 32'h0);
    send(F_REMOVE, 8'd4, 32'h0);

    // limit below the count; full wins over a bad index
    set_capacity(2);
    send(F_APPEND, 8'd0, 32'h3333_3333);
    send(F_INSERT, 8'd200, 32'h4444_4444);
    send(F_DROP, 8'd0, 32'h0);
    send(F_DROP, 8'd0, 32'h0);
    send(F_APPEND, 8'd0, 32'h5555_5555);
    send(F_DROP, 8'd0, 32'h0);
    send(F_APPEND, 8'd0, 32'h6666_6666);

    set_capacity(0);
    send(F_APPEND, 8'd0, 32'h7777_7777);
    send(F_INSERT, 8'd0, 32'h8888_8888);
    send(F_READ, 8'd1, 32'h0);

    set_capacity(256);
    run_phase(330, MIX_GROW, 255);
    set_capacity(100);
    run_phase(130, MIX_DRAIN, 120);
    set_capacity(1);
    run_phase(90, MIX_EVEN, 2);
    cap_pick = $urandom_range(2, 255);
    set_capacity(cap_pick);
    run_phase(190, MIX_EVEN, cap_pick);
    set_capacity(256);
    run_phase(160, MIX_GROW, 255);
    calm = 1'b1;
    run_phase(170, MIX_EVEN, 255);

    settle();
    repeat (270) @(posedge clk);
    $display("%0d list requests sent across %0d capacity settings", items_sent, settings_used);
    $display("%0d replies checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #25_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/clel_pkg.sv
rtl/clel_ram.sv
rtl/clel_ctrl.sv
rtl/clel_dp.sv
rtl/contiguous_list_engine_top.sv
bench/list_checker.sv
bench/tb_contiguous_list_engine_top.sv
